>>> sv/es2d_pkg.sv
// Shared types and constants for the epoch seconds to date converter.
`default_nettype none
package es2d_pkg;

  localparam logic [31:0] LimitSec   = 32'd4102444800;
  localparam logic [30:0] RecipDiv15 = 31'd1145324612;  // floor(2^34/15)
  localparam logic [26:0] RecipDiv60 = 27'd71582788;    // floor(2^32/60)
  localparam logic [19:0] RecipDiv24 = 20'd699050;      // floor(2^24/24)
  localparam logic [15:0] RecipQuad  = 16'd45933;       // floor(2^26/1461)
  localparam logic [15:0] DaysTo1970 = 16'd731;         // from 1968-01-01
  localparam logic [10:0] QuadDays   = 11'd1461;
  localparam logic [11:0] BaseYear   = 12'd1968;

  typedef struct packed {
    logic        unset;
    logic        oor;
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } tsplit_t;

  typedef struct packed {
    logic        unset;
    logic        oor;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } date_t;

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    unique case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd365;
    endcase
    if (leap && (m >= 4'd2) && (m <= 4'd11)) s = s + 9'd1;
    return s;
  endfunction

endpackage
`default_nettype wire

>>> sv/es2d_time_split.sv
// Seconds to day count, hour and minute: three reciprocal-multiply stages.
`default_nettype none
module es2d_time_split import es2d_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] ts,
  output logic             vld,
  output tsplit_t          res
);

  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic [1:0]  f1_r, f2_r, f3_r, f4_r, f5_r, f6_r, f7_r;
  logic [31:0] ts1_r;
  logic [29:0] x2_r;
  logic [60:0] p2_r;
  logic [26:0] mt3_r, mt4_r;
  logic [53:0] p4_r;
  logic [20:0] h5_r, h6_r;
  logic [5:0]  mn5_r, mn6_r, mn7_r;
  logic [40:0] p6_r;
  logic [15:0] d7_r;
  logic [4:0]  hr7_r;

  logic [26:0] q3;
  logic [30:0] r3;
  logic [20:0] q5;
  logic [27:0] r5;
  logic [16:0] q7;
  logic [21:0] r7;

  always_comb begin
    q3 = p2_r[60:34];
    r3 = {1'b0, x2_r} - (({4'd0, q3} << 4) - {4'd0, q3});
    q5 = p4_r[52:32];
    r5 = {1'b0, mt4_r} - (({7'd0, q5} << 6) - ({7'd0, q5} << 2));
    q7 = p6_r[40:24];
    r7 = {1'b0, h6_r} - (({5'd0, q7} << 4) + ({5'd0, q7} << 3));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r} <= '0;
    end else if (en) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r} <= {in_valid, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ts1_r <= ts;
      f1_r  <= {ts == 32'd0, ts >= LimitSec};
      x2_r  <= ts1_r[31:2];
      p2_r  <= ts1_r[31:2] * RecipDiv15;
      f2_r  <= f1_r;
      mt3_r <= (r3 >= 31'd15) ? q3 + 27'd1 : q3;
      f3_r  <= f2_r;
      mt4_r <= mt3_r;
      p4_r  <= mt3_r * RecipDiv60;
      f4_r  <= f3_r;
      h5_r  <= (r5 >= 28'd60) ? q5 + 21'd1 : q5;
      mn5_r <= (r5 >= 28'd60) ? 6'(r5 - 28'd60) : r5[5:0];
      f5_r  <= f4_r;
      h6_r  <= h5_r;
      p6_r  <= h5_r * RecipDiv24;
      mn6_r <= mn5_r;
      f6_r  <= f5_r;
      d7_r  <= (r7 >= 22'd24) ? 16'(q7 + 17'd1) : q7[15:0];
      hr7_r <= (r7 >= 22'd24) ? 5'(r7 - 22'd24) : r7[4:0];
      mn7_r <= mn6_r;
      f7_r  <= f6_r;
    end
  end

  assign vld        = v7_r;
  assign res.unset  = f7_r[1];
  assign res.oor    = f7_r[0];
  assign res.days   = d7_r;
  assign res.hour   = hr7_r;
  assign res.minute = mn7_r;

endmodule
`default_nettype wire

>>> sv/es2d_date_split.sv
// Day count to year, month and day through four-year cycles.
`default_nettype none
module es2d_date_split import es2d_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    in_vld,
  input  wire tsplit_t ts_in,
  output logic         vld,
  output date_t        res
);

  logic        v8_r, v9_r, v10_r, v11_r;
  tsplit_t     t8_r, t9_r, t10_r, t11_r;
  logic [15:0] d8_r;
  logic [31:0] p8_r;
  logic [5:0]  q9_r;
  logic [10:0] r9_r;
  logic [11:0] y10_r, y11_r;
  logic [8:0]  doy10_r, doy11_r;
  logic        lp10_r, lp11_r;
  logic [3:0]  m11_r;

  logic [5:0]  q8;
  logic [16:0] r8;
  logic [1:0]  yq;
  logic [8:0]  doy;
  logic [3:0]  mcnt;
  logic [8:0]  dd;

  always_comb begin
    q8 = p8_r[31:26];
    r8 = {1'b0, d8_r} - ({11'd0, q8} * {6'd0, QuadDays});
    if (r9_r < 11'd366) begin
      yq = 2'd0; doy = r9_r[8:0];
    end else if (r9_r < 11'd731) begin
      yq = 2'd1; doy = 9'(r9_r - 11'd366);
    end else if (r9_r < 11'd1096) begin
      yq = 2'd2; doy = 9'(r9_r - 11'd731);
    end else begin
      yq = 2'd3; doy = 9'(r9_r - 11'd1096);
    end
    mcnt = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy10_r >= month_start(4'(m), lp10_r)) mcnt = mcnt + 4'd1;
    end
    dd = doy11_r - month_start(m11_r, lp11_r) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v8_r, v9_r, v10_r, v11_r} <= '0;
    end else if (en) begin
      {v8_r, v9_r, v10_r, v11_r} <= {in_vld, v8_r, v9_r, v10_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t8_r    <= ts_in;
      d8_r    <= ts_in.days + DaysTo1970;
      p8_r    <= (ts_in.days + DaysTo1970) * RecipQuad;
      t9_r    <= t8_r;
      q9_r    <= (r8 >= 17'(QuadDays)) ? q8 + 6'd1 : q8;
      r9_r    <= (r8 >= 17'(QuadDays)) ? 11'(r8 - 17'(QuadDays)) : r8[10:0];
      t10_r   <= t9_r;
      y10_r   <= BaseYear + {4'd0, q9_r, 2'd0} + {10'd0, yq};
      doy10_r <= doy;
      lp10_r  <= (yq == 2'd0);
      t11_r   <= t10_r;
      y11_r   <= y10_r;
      doy11_r <= doy10_r;
      lp11_r  <= lp10_r;
      m11_r   <= mcnt;
    end
  end

  assign vld        = v11_r;
  assign res.unset  = t11_r.unset;
  assign res.oor    = t11_r.oor;
  assign res.year   = y11_r;
  assign res.month  = m11_r + 4'd1;
  assign res.day    = dd[4:0];
  assign res.hour   = t11_r.hour;
  assign res.minute = t11_r.minute;

endmodule
`default_nettype wire

>>> sv/epoch_seconds_to_date.sv
// Top level: Unix seconds to civil date and time of day, 12-stage pipeline.
//
// Input channel in_valid/in_stall carries in_epoch_seconds (unsigned 32 bits).
// Output channel out_valid/out_stall carries the flags and year, month, day,
// hour, minute. A transfer happens when valid is high and stall is low.
// One result comes out per accepted item, in order.
// Throughput is one item per cycle while out_stall does not hold the
// pipeline. Division by 60, 60, 24 and 1461 is done by reciprocal
// multiplies, each one register stage with a correction stage after it.
// A zero input raises out_is_unset with 1970-01-01 00:00; inputs at or past
// 2100-01-01 raise out_out_of_range and show 2099-12-31 23:59.
// Reset (rst_n low, synchronous) empties the pipeline and drops out_valid.
// When a result is held by out_stall, the whole pipeline freezes and
// in_stall rises; nothing is lost or repeated.
`default_nettype none
module epoch_seconds_to_date import es2d_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_unset,
  output logic             out_out_of_range,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute
);

  logic    en;
  logic    tv, dv;
  tsplit_t tres;
  date_t   dres;
  date_t   out_r;
  logic    out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  es2d_time_split u_time (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .ts(in_epoch_seconds), .vld(tv), .res(tres)
  );

  es2d_date_split u_date (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(tv),
    .ts_in(tres), .vld(dv), .res(dres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (dres.unset) begin
        out_r <= '{unset: 1'b1, oor: 1'b0, year: 12'd1970, month: 4'd1, day: 5'd1,
                   hour: 5'd0, minute: 6'd0};
      end else if (dres.oor) begin
        out_r <= '{unset: 1'b0, oor: 1'b1, year: 12'd2099, month: 4'd12, day: 5'd31,
                   hour: 5'd23, minute: 6'd59};
      end else begin
        out_r <= dres;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_unset     = out_r.unset;
  assign out_out_of_range = out_r.oor;
  assign out_year         = out_r.year;
  assign out_month        = out_r.month;
  assign out_day          = out_r.day;
  assign out_hour         = out_r.hour;
  assign out_minute       = out_r.minute;

endmodule
`default_nettype wire

>>> tb/tb_epoch_seconds_to_date.sv
// Testbench for the epoch seconds to date converter: random and directed timestamps, scoreboard.
`default_nettype none
module tb_epoch_seconds_to_date;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        unset;
    logic        oor;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } civil_t;

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic civil_t civil_of(logic [31:0] ts);
    civil_t r;
    int unsigned t, days, ylen, mlen, m;
    int unsigned mdays[12];
    mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    r = '{1'b0, 1'b0, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0};
    if (ts == 0) begin
      r.unset = 1'b1;
    end else if (ts >= 32'd4102444800) begin
      r = '{1'b0, 1'b1, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59};
    end else begin
      t = ts / 60;
      r.minute = 6'(t % 60);
      t = t / 60;
      r.hour = 5'(t % 24);
      days = t / 24;
      while (r.year < 2099) begin
        ylen = is_leap(r.year) ? 366 : 365;
        if (days < ylen) break;
        days -= ylen;
        r.year++;
      end
      m = 0;
      while (m < 12) begin
        mlen = (m == 1 && is_leap(r.year)) ? 29 : mdays[m];
        if (days < mlen) break;
        days -= mlen;
        m++;
      end
      if (m > 11) begin
        m = 11;
        days = 30;
      end
      r.month = 4'(m + 1);
      r.day = 5'(days + 1);
    end
    return r;
  endfunction

  class date_scoreboard;
    civil_t pending[$];
    int errors = 0;
    int checked = 0;
    function void note_input(logic [31:0] ts);
      pending.push_back(civil_of(ts));
    endfunction
    function void check_result(civil_t got);
      civil_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  civil_t res;

  date_scoreboard sb = new();
  int long_hold = 0;
  bit stim_done = 0;
  int n_oor = 0, n_unset = 0;

  epoch_seconds_to_date u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_epoch_seconds(in_epoch_seconds), .out_valid(out_valid), .out_stall(out_stall),
    .out_is_unset(res.unset), .out_out_of_range(res.oor), .out_year(res.year),
    .out_month(res.month), .out_day(res.day), .out_hour(res.hour), .out_minute(res.minute)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_epoch_seconds);
    if (rst_n && out_valid && !out_stall) sb.check_result(res);
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else begin
        mode = (sb.checked / 200) % 3;
        out_stall <= (mode == 0) ? 1'b0 : (mode == 1) ? ($urandom_range(3) == 0)
                                                       : ($urandom_range(1) == 0);
      end
    end
  end

  task automatic send(logic [31:0] ts);
    in_valid <= 1'b1;
    in_epoch_seconds <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_ts();
    int k;
    k = $urandom_range(9);
    if (k == 0) return $urandom();
    if (k == 1) return 32'd4102444800 + $urandom_range(200) - 100;
    if (k == 2) return $urandom_range(2);
    if (k == 3) return $urandom_range(129) * 32'd31556952 + $urandom_range(172800) - 86400;
    return $urandom_range(32'd4102444799, 1);
  endfunction

  initial begin
    logic [31:0] dir[$];
    logic [31:0] v;
    int burst;
    dir = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
            32'd68169600, 32'd68256000, 32'd951782400, 32'd951868800, 32'd946684799,
            32'd2147483647, 32'd2147483648, 32'd4102444799, 32'd4102444800,
            32'd4102444801, 32'hFFFFFFFF, 32'd4107542400, 32'd4070908800,
            32'd4107455999, 32'd31535999, 32'd31536000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send(dir[i]);
    idle(1);
    while (sb.pending.size() != 0) @(posedge clk);
    long_hold = 60;
    for (int i = 0; i < 40; i++) send(rand_ts());
    for (int i = 0; i < 1950; ) begin
      burst = $urandom_range(30, 1);
      for (int j = 0; j < burst; j++) begin
        v = rand_ts();
        if (v == 0) n_unset++;
        if (v >= 32'd4102444800) n_oor++;
        send(v);
      end
      i += burst;
      if ($urandom_range(3) != 0) idle($urandom_range(6, 1));
    end
    idle(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("checked %0d results: directed edges, leap and century years, %0d zero, %0d past 2099",
             sb.checked, n_unset, n_oor);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
sv/es2d_pkg.sv
sv/es2d_time_split.sv
sv/es2d_date_split.sv
sv/epoch_seconds_to_date.sv
tb/tb_epoch_seconds_to_date.sv
